FILE: sv/binary_search_leftmost_match_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the leftmost-match search unit
// ---------------------------------------------------------------------------
`ifndef BINARY_SEARCH_LEFTMOST_MATCH_UNIT_MACROS_SVH
`define BINARY_SEARCH_LEFTMOST_MATCH_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BSLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bslm_pkg.sv
// ---------------------------------------------------------------------------
// bslm_pkg
// Types and constants shared by the leftmost-match search unit and its checker.
// ---------------------------------------------------------------------------
package bslm_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int SPAN_W = IDX_W + 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     opcode;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } result_t;

endpackage

FILE: sv/binary_search_leftmost_match_unit.sv
// A write gives no result. A search over n positions makes at most
// floor(log2(n))+1 probes, one per cycle, then loads the result register
// once it is free. The unit takes no new request while a search is in
// progress or its result waits to be loaded. Reset clears control state
// only; table contents are undefined until written.
// ---------------------------------------------------------------------------
// binary_search_leftmost_match_unit
// Table of signed entries in one synchronous memory, searched by halving.
// ---------------------------------------------------------------------------
module binary_search_leftmost_match_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bslm_pkg::request_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bslm_pkg::result_t  out_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef logic [bslm_pkg::SPAN_W-1:0] span_t;

  state_t                            state_r, state_nxt;
  span_t                             lo_r, lo_nxt;
  span_t                             hip1_r, hip1_nxt;
  span_t                             mid_r, mid_nxt;
  logic signed [bslm_pkg::VAL_W-1:0] key_r, key_nxt;
  logic                              found_r, found_nxt;
  logic [bslm_pkg::IDX_W-1:0]        pos_r, pos_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bslm_pkg::result_t                 out_data_r, out_data_nxt;

  logic signed [bslm_pkg::VAL_W-1:0] mem [bslm_pkg::DEPTH];
  logic signed [bslm_pkg::VAL_W-1:0] rdata_r;
  logic                              rd_en;
  logic [bslm_pkg::ADDR_W-1:0]       rd_addr;
  logic                              wr_en;

  logic  in_accept;
  span_t req_lo;
  span_t req_hip1;
  span_t step_lo;
  span_t step_hip1;
  logic  step_found;
  logic [bslm_pkg::IDX_W-1:0] step_pos;

  // middle of [lo, hip1-1]; caller guarantees lo < hip1
  function automatic span_t mid_of(input span_t lo, input span_t hip1);
    span_t diff;
    diff = hip1 - lo - span_t'(1);
    return lo + (diff >> 1);
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_en = in_accept && (in_data.opcode == bslm_pkg::OP_WRITE)
                 && (int'(in_data.entry_index) < bslm_pkg::DEPTH);

  // clamp the exclusive upper bound to the table size
  always_comb begin
    req_lo   = span_t'(in_data.range_low);
    req_hip1 = span_t'(in_data.range_high) + span_t'(1);
    if (int'(req_hip1) > bslm_pkg::DEPTH) begin
      req_hip1 = span_t'(bslm_pkg::DEPTH);
    end
  end

  // one halving step on the entry read at mid_r
  always_comb begin
    step_lo    = lo_r;
    step_hip1  = hip1_r;
    step_found = found_r;
    step_pos   = pos_r;
    if (rdata_r >= key_r) begin
      step_hip1 = mid_r;
      if (rdata_r == key_r) begin
        step_found = 1'b1;
        step_pos   = mid_r[bslm_pkg::IDX_W-1:0];
      end
    end else begin
      step_lo = mid_r + span_t'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_data.opcode == bslm_pkg::OP_SEARCH)) begin
          key_nxt   = in_data.search_key;
          lo_nxt    = req_lo;
          hip1_nxt  = req_hip1;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          if (req_lo < req_hip1) begin
            mid_nxt   = mid_of(req_lo, req_hip1);
            rd_en     = 1'b1;
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        lo_nxt    = step_lo;
        hip1_nxt  = step_hip1;
        found_nxt = step_found;
        pos_nxt   = step_pos;
        if (step_lo < step_hip1) begin
          mid_nxt = mid_of(step_lo, step_hip1);
          rd_en   = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = found_r;
          out_data_nxt.position = pos_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = bslm_pkg::ADDR_W'(mid_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[bslm_pkg::ADDR_W'(in_data.entry_index)] <= in_data.entry_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hip1_r     <= hip1_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: sv/bslm_checker.sv
// ---------------------------------------------------------------------------
// bslm_checker
// Port-level checks for the leftmost-match search unit, bound to the top.
// ---------------------------------------------------------------------------
`include "binary_search_leftmost_match_unit_macros.svh"

module bslm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bslm_pkg::request_t in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bslm_pkg::result_t  out_data
);

  logic out_held;
  logic miss;
  logic write_req;
  logic search_req;

  assign out_held   = out_valid && out_stall;
  assign miss       = out_valid && !out_data.found;
  assign write_req  = in_valid && !in_stall && (in_data.opcode == bslm_pkg::OP_WRITE);
  assign search_req = in_valid && !in_stall && (in_data.opcode == bslm_pkg::OP_SEARCH);

  `BSLM_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result dropped while stalled")
  `BSLM_ASSERT_NEXT(a_out_stable, out_held, $stable(out_data), "stalled result changed")
  `BSLM_ASSERT_NOW(a_miss_zero, miss, out_data.position == '0, "miss with nonzero position")
  `BSLM_ASSERT_NEXT(a_write_one_cycle, write_req, !in_stall, "write request blocked the input")
  `BSLM_ASSERT_NEXT(a_search_busy, search_req, in_stall, "search request did not block input")

endmodule

bind binary_search_leftmost_match_unit bslm_checker u_bslm_checker (.*);
